// ===== rtl/tts_pkg.sv =====
// Package for the traffic table threat select block: payload structs, slot constants,
// register indexes and mode codes. Depends on nothing.
`default_nettype none
package tts_pkg;
   localparam int SLOTS = 8;
   localparam int SLOT_W = 3;

   localparam logic [2:0] CSR_WARN  = 3'd0;
   localparam logic [2:0] CSR_ALERT = 3'd1;
   localparam logic [2:0] CSR_MAXV  = 3'd2;
   localparam logic [2:0] CSR_MEET  = 3'd3;
   localparam logic [2:0] CSR_RANGE = 3'd4;
   localparam logic [2:0] CSR_KEEP  = 3'd5;

   localparam logic MODE_REPORT  = 1'b0;
   localparam logic MODE_REFRESH = 1'b1;

   typedef struct packed {
      logic               mode;
      logic [23:0]        icao;
      logic               pos_valid;
      logic [7:0]         since_seen_s;
      logic               gps_ok;
      logic [2:0]         slot;
      logic               age_tick;
      logic [31:0]        dist_cm;
      logic signed [31:0] vert_cm;
      logic [15:0]        meet_dist_m;
      logic [15:0]        meet_time_s;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic [2:0]  stored_slot;
      logic        warn_found;
      logic [2:0]  warn_slot;
      logic        alert_found;
      logic [2:0]  alert_slot;
      logic [3:0]  active_count;
      logic [31:0] message_count;
   } rsp_type;
endpackage
`default_nettype wire

// ===== rtl/traffic_table_threat_select.sv =====
// Top level of the traffic table threat select block: slot table, scan sequencer and
// shared compare unit. Depends on tts_pkg.
//
// Usage: req_valid/req_ready carry one item (report or refresh) as a tts_pkg::req_type.
// rsp_valid/rsp_ready return one tts_pkg::rsp_type per item. csr_we writes register
// csr_index with csr_wdata at once; write only while idle.
// Sequence: a slot search (one slot a cycle through one shared distance
// comparator), an update step, then a threat scan over the slots, after which
// rsp_valid rises and the result waits for rsp_ready. A new item is taken the
// cycle after the result has been transferred, so the block does not take a new
// item before the last one is through its two one-slot-per-cycle scans. While the
// receiver stalls the result holds and req_ready stays low.
// Reset clears identifiers, time-to-live, calculated flags, the message counter and
// loads register defaults; geometry stores are left unset until written.
`default_nettype none
module traffic_table_threat_select (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire tts_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output tts_pkg::rsp_type      rsp_data,
   input  wire logic             csr_we,
   input  wire logic [2:0]       csr_index,
   input  wire logic [31:0]      csr_wdata
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_FIND = 3'd1;
   localparam logic [2:0] ST_UPD  = 3'd2;
   localparam logic [2:0] ST_SCAN = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [tts_pkg::SLOT_W-1:0] idx_ff, idx_in;
   logic [tts_pkg::SLOT_W-1:0] ix;
   tts_pkg::req_type req_ff;

   logic [31:0] warn_cm_ff, alert_cm_ff, range_cm_ff;
   logic signed [31:0] maxv_ff;
   logic meet_en_ff;
   logic [7:0] keep_ff;

   logic [23:0] ident_ff [tts_pkg::SLOTS];
   logic [7:0]  life_ff [tts_pkg::SLOTS];
   logic        calc_ff [tts_pkg::SLOTS];
   logic [31:0] dist_ff [tts_pkg::SLOTS];
   logic signed [31:0] vert_ff [tts_pkg::SLOTS];
   logic [15:0] mdist_ff [tts_pkg::SLOTS];
   logic [15:0] mtime_ff [tts_pkg::SLOTS];
   logic [31:0] count_ff;

   // search results
   logic found_ok_ff, free_ok_ff, unc_ok_ff, far_ok_ff;
   logic [2:0] found_ff, free_ff, unc_ff, far_ff;
   logic [31:0] far_dist_ff;
   // scan results
   logic warn_ok_ff, alert_ok_ff;
   logic [2:0] warn_ff, alert_ff;
   logic [31:0] warn_dist_ff;
   logic [15:0] best_t_ff;
   logic [3:0] active_ff;
   logic acc_ff;
   logic [2:0] stored_ff;

   assign ix = idx_ff;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_data = '{accepted: acc_ff, stored_slot: stored_ff,
                       warn_found: warn_ok_ff, warn_slot: warn_ok_ff ? warn_ff : 3'd0,
                       alert_found: alert_ok_ff, alert_slot: alert_ok_ff ? alert_ff : 3'd0,
                       active_count: active_ff, message_count: count_ff};

   // shared unit: one 32-bit magnitude compare, its operands chosen by state
   // search: farther than the best so far; scan: nearer than the best so far
   logic [31:0] cmp_a, cmp_b;
   logic cmp_lt;
   always_comb begin
      cmp_a = (state_ff == ST_FIND) ? dist_ff[ix] : warn_dist_ff;
      cmp_b = (state_ff == ST_FIND) ? far_dist_ff : dist_ff[ix];
      cmp_lt = cmp_b < cmp_a;
   end

   // threat terms of the scanned slot
   logic live, high, in_warn, in_alert, pred, mfar, alert_hit;
   logic [15:0] t_cur;
   always_comb begin
      live = (life_ff[ix] != 8'd0) && calc_ff[ix];
      high = (vert_ff[ix] > 0) && (maxv_ff > 0) && (vert_ff[ix] > maxv_ff);
      in_warn = dist_ff[ix] < warn_cm_ff;
      in_alert = dist_ff[ix] <= alert_cm_ff;
      mfar = ({17'd0, mdist_ff[ix]} * 40'd100) > {8'd0, alert_cm_ff};
      pred = meet_en_ff && (dist_ff[ix] <= warn_cm_ff) && (mdist_ff[ix] != 16'd0);
      t_cur = in_alert ? 16'd0 : mtime_ff[ix];
      alert_hit = live && !high && (in_alert || (pred && !mfar));
   end

   // pick of the report slot
   logic pick_ok;
   logic [2:0] pick;
   always_comb begin
      pick_ok = 1'b0;
      pick = 3'd0;
      priority if (found_ok_ff) begin
         pick_ok = 1'b1; pick = found_ff;
      end else if (free_ok_ff) begin
         pick_ok = 1'b1; pick = free_ff;
      end else if (req_ff.gps_ok && unc_ok_ff) begin
         pick_ok = 1'b1; pick = unc_ff;
      end else if (req_ff.gps_ok && far_ok_ff && !(req_ff.dist_cm > far_dist_ff)) begin
         pick_ok = 1'b1; pick = far_ff;
      end
   end

   logic rep_ok, stale;
   assign rep_ok = (req_ff.icao != 24'd0) && req_ff.pos_valid;
   assign stale = req_ff.since_seen_s > keep_ff;

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) begin
            state_in = ST_FIND; idx_in = '0;
         end
         ST_FIND: if (idx_ff == tts_pkg::SLOTS - 1) state_in = ST_UPD;
                  else idx_in = idx_ff + 1'b1;
         ST_UPD: begin
            state_in = ST_SCAN; idx_in = '0;
         end
         ST_SCAN: if (idx_ff == tts_pkg::SLOTS - 1) state_in = ST_OUT;
                  else idx_in = idx_ff + 1'b1;
         ST_OUT: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // control and table state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff <= '0;
         count_ff <= '0;
         warn_cm_ff <= 32'd300000;
         alert_cm_ff <= 32'd100000;
         maxv_ff <= '0;
         meet_en_ff <= 1'b1;
         range_cm_ff <= 32'd5000000;
         keep_ff <= 8'd10;
         for (int i = 0; i < tts_pkg::SLOTS; i++) begin
            ident_ff[i] <= '0; life_ff[i] <= '0; calc_ff[i] <= 1'b0;
         end
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         if (csr_we) begin
            unique case (csr_index)
               tts_pkg::CSR_WARN:  warn_cm_ff <= csr_wdata;
               tts_pkg::CSR_ALERT: alert_cm_ff <= csr_wdata;
               tts_pkg::CSR_MAXV:  maxv_ff <= csr_wdata;
               tts_pkg::CSR_MEET:  meet_en_ff <= csr_wdata[0];
               tts_pkg::CSR_RANGE: range_cm_ff <= csr_wdata;
               tts_pkg::CSR_KEEP:  keep_ff <= csr_wdata[7:0];
               default: ;
            endcase
         end
         if (state_ff == ST_UPD) begin
            if (req_ff.mode == tts_pkg::MODE_REPORT) begin
               if (rep_ok) begin
                  count_ff <= count_ff + 32'd1;
                  if (stale) begin
                     if (found_ok_ff) life_ff[found_ff] <= '0;
                  end else if (pick_ok) begin
                     ident_ff[pick] <= req_ff.icao;
                     if (!req_ff.gps_ok) begin
                        life_ff[pick] <= keep_ff - req_ff.since_seen_s;
                        calc_ff[pick] <= 1'b0;
                     end else if (req_ff.dist_cm > range_cm_ff) begin
                        life_ff[pick] <= '0;
                        calc_ff[pick] <= 1'b0;
                     end else begin
                        life_ff[pick] <= keep_ff - req_ff.since_seen_s;
                        calc_ff[pick] <= 1'b1;
                     end
                  end
               end
            end else if (life_ff[req_ff.slot] != 8'd0) begin
               if (life_ff[req_ff.slot] - {7'd0, req_ff.age_tick} != 8'd0) begin
                  if (req_ff.dist_cm > range_cm_ff) begin
                     life_ff[req_ff.slot] <= '0;
                     calc_ff[req_ff.slot] <= 1'b0;
                  end else begin
                     life_ff[req_ff.slot] <= life_ff[req_ff.slot] - {7'd0, req_ff.age_tick};
                     calc_ff[req_ff.slot] <= 1'b1;
                  end
               end else begin
                  life_ff[req_ff.slot] <= '0;
               end
            end
         end
      end
   end

   // geometry, search and scan registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) req_ff <= req_data;
      unique case (state_ff)
         ST_IDLE: begin
            found_ok_ff <= 1'b0; free_ok_ff <= 1'b0;
            unc_ok_ff <= 1'b0; far_ok_ff <= 1'b0;
         end
         ST_FIND: begin
            if (!found_ok_ff && ident_ff[ix] == req_ff.icao) begin
               found_ok_ff <= 1'b1; found_ff <= ix;
            end
            if (!free_ok_ff && life_ff[ix] == 8'd0) begin
               free_ok_ff <= 1'b1; free_ff <= ix;
            end
            if (!unc_ok_ff && !calc_ff[ix]) begin
               unc_ok_ff <= 1'b1; unc_ff <= ix;
            end
            if (life_ff[ix] != 8'd0 && calc_ff[ix] && (!far_ok_ff || cmp_lt)) begin
               far_ok_ff <= 1'b1; far_ff <= ix; far_dist_ff <= dist_ff[ix];
            end
         end
         ST_UPD: begin
            warn_ok_ff <= 1'b0; alert_ok_ff <= 1'b0; active_ff <= '0;
            acc_ff <= 1'b0; stored_ff <= '0;
            if (req_ff.mode == tts_pkg::MODE_REPORT) begin
               if (rep_ok && !stale && pick_ok) begin
                  acc_ff <= 1'b1; stored_ff <= pick;
                  if (req_ff.gps_ok) begin
                     dist_ff[pick] <= req_ff.dist_cm;
                     if (!(req_ff.dist_cm > range_cm_ff)) begin
                        vert_ff[pick] <= req_ff.vert_cm;
                        if (meet_en_ff) begin
                           mdist_ff[pick] <= req_ff.meet_dist_m;
                           mtime_ff[pick] <= req_ff.meet_time_s;
                        end
                     end
                  end
               end
            end else if (life_ff[req_ff.slot] != 8'd0 &&
                         life_ff[req_ff.slot] - {7'd0, req_ff.age_tick} != 8'd0) begin
               dist_ff[req_ff.slot] <= req_ff.dist_cm;
               if (!(req_ff.dist_cm > range_cm_ff)) begin
                  vert_ff[req_ff.slot] <= req_ff.vert_cm;
                  if (meet_en_ff) begin
                     mdist_ff[req_ff.slot] <= req_ff.meet_dist_m;
                     mtime_ff[req_ff.slot] <= req_ff.meet_time_s;
                  end
               end
            end
         end
         ST_SCAN: begin
            if (life_ff[ix] != 8'd0) active_ff <= active_ff + 4'd1;
            if (live && !high && in_warn && (!warn_ok_ff || cmp_lt)) begin
               warn_ok_ff <= 1'b1; warn_ff <= ix; warn_dist_ff <= dist_ff[ix];
            end
            if (alert_hit && (!alert_ok_ff || t_cur < best_t_ff)) begin
               alert_ok_ff <= 1'b1; alert_ff <= ix; best_t_ff <= t_cur;
            end
         end
         default: ;
      endcase
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid) else $error("ready while result pending");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed under stall");
   a_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_FIND && idx_ff == 0)
      else $error("transfer did not start search");
   a_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> active_ff <= tts_pkg::SLOTS) else $error("active count too large");
endmodule
`default_nettype wire
